// ===== design/hrpg_pkg.sv =====
// Package for the heart-rate phase-gate average unit.
// Holds field widths, register indexes, reset values, controller states
// and the command and status structs. Depends on nothing.
package hrpg_pkg;

   localparam int PHASE_W = 16;
   localparam int LIMIT_W = 15;
   localparam int RATE_W = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 15;

   localparam int RING_DEPTH_DEFAULT = 10;

   localparam logic [LIMIT_W-1:0] PHASE_LIMIT_RESET = 15'd3277;
   localparam logic [RATE_W-1:0] RATE_LOW_RESET = 12'd640;
   localparam logic [RATE_W-1:0] RATE_HIGH_RESET = 12'd1920;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PHASE_LIMIT = 2'd0,
      REG_RATE_LOW = 2'd1,
      REG_RATE_HIGH = 2'd2
   } hrpg_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_UPDATE,
      ST_DIVIDE,
      ST_RESPOND
   } hrpg_state_type;

   typedef struct packed {
      logic load;
      logic check;
      logic update;
      logic div_step;
   } hrpg_cmd_type;

   typedef struct packed {
      logic store;
      logic div_done;
   } hrpg_status_type;

endpackage

// ===== design/hrpg_req_if.sv =====
// Request channel interface: heart phase sample with an optional rate.
// Depends on hrpg_pkg for the field widths.
interface hrpg_req_if;
   logic valid;
   logic ready;
   logic signed [hrpg_pkg::PHASE_W-1:0] phase_sample;
   logic rate_present;
   logic [hrpg_pkg::RATE_W-1:0] raw_rate;

   modport source (output valid, phase_sample, rate_present, raw_rate, input ready);
   modport sink (input valid, phase_sample, rate_present, raw_rate, output ready);
endinterface

// ===== design/hrpg_rsp_if.sv =====
// Response channel interface: phase verdict and averaged rate.
// Depends on hrpg_pkg for the field widths.
interface hrpg_rsp_if;
   logic valid;
   logic ready;
   logic phase_ok;
   logic rate_valid;
   logic [hrpg_pkg::RATE_W-1:0] rate_mean;

   modport source (output valid, phase_ok, rate_valid, rate_mean, input ready);
   modport sink (input valid, phase_ok, rate_valid, rate_mean, output ready);
endinterface

// ===== design/hrpg_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module hrpg_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 10
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hrpg_ctrl.sv =====
// Controller for the heart-rate phase-gate average unit.
// Sequences load, phase check, ring update, divide and response.
// Depends on hrpg_pkg.
module hrpg_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  hrpg_pkg::hrpg_status_type status,
   output hrpg_pkg::hrpg_cmd_type    cmd
);

   hrpg_pkg::hrpg_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrpg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         hrpg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = hrpg_pkg::ST_CHECK;
            end
         end
         hrpg_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            state_in = status.store ? hrpg_pkg::ST_UPDATE : hrpg_pkg::ST_RESPOND;
         end
         hrpg_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = hrpg_pkg::ST_DIVIDE;
         end
         hrpg_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = hrpg_pkg::ST_RESPOND;
            end
         end
         hrpg_pkg::ST_RESPOND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = hrpg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hrpg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/hrpg_dpath.sv =====
// Datapath for the heart-rate phase-gate average unit: settings registers,
// phase gate, rate ring with running sum and count, and a restoring divider.
// Depends on hrpg_pkg and hrpg_ram.
module hrpg_dpath #(
   parameter int RING_DEPTH = hrpg_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [hrpg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [hrpg_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic signed [hrpg_pkg::PHASE_W-1:0]   phase_sample,
   input  logic                                  rate_present,
   input  logic [hrpg_pkg::RATE_W-1:0]           raw_rate,
   input  hrpg_pkg::hrpg_cmd_type                cmd,
   output hrpg_pkg::hrpg_status_type             status,
   output logic                                  phase_ok,
   output logic                                  rate_valid,
   output logic [hrpg_pkg::RATE_W-1:0]           rate_mean
);

   localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int SUM_W = hrpg_pkg::RATE_W + CNT_W;
   localparam int STEP_W = $clog2(SUM_W);
   localparam int PW = hrpg_pkg::PHASE_W;
   localparam int RW = hrpg_pkg::RATE_W;
   localparam int LW = hrpg_pkg::LIMIT_W;

   // Settings registers.
   logic [LW-1:0] phase_limit_ff;
   logic [RW-1:0] rate_low_ff;
   logic [RW-1:0] rate_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_limit_ff <= hrpg_pkg::PHASE_LIMIT_RESET;
         rate_low_ff <= hrpg_pkg::RATE_LOW_RESET;
         rate_high_ff <= hrpg_pkg::RATE_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            hrpg_pkg::REG_PHASE_LIMIT: phase_limit_ff <= csr_wdata[LW-1:0];
            hrpg_pkg::REG_RATE_LOW: rate_low_ff <= csr_wdata[RW-1:0];
            hrpg_pkg::REG_RATE_HIGH: rate_high_ff <= csr_wdata[RW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Captured transaction.
   logic signed [PW-1:0] phase_ff;
   logic present_ff;
   logic [RW-1:0] rate_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         phase_ff <= phase_sample;
         present_ff <= rate_present;
         rate_ff <= raw_rate;
      end
   end

   // Phase gate on a 17-bit difference.
   logic signed [PW-1:0] prior_ff;
   logic signed [PW:0] diff;
   logic [PW:0] mag;
   logic ok;
   logic store;

   assign diff = {phase_ff[PW-1], phase_ff} - {prior_ff[PW-1], prior_ff};
   assign mag = diff[PW] ? (~diff + 1'b1) : diff;
   assign ok = (prior_ff == '0) || (mag < {2'b00, phase_limit_ff});
   assign store = ok && present_ff && (rate_ff >= rate_low_ff) && (rate_ff <= rate_high_ff);

   logic ok_ff;
   logic store_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff <= '0;
         ok_ff <= 1'b0;
         store_ff <= 1'b0;
      end else if (cmd.check) begin
         prior_ff <= phase_ff;
         ok_ff <= ok;
         store_ff <= store;
      end
   end

   // Ring storage. Entries past the write slot read as zero until the ring
   // has wrapped once, so no clearing pass is needed after reset.
   logic [SLOT_W-1:0] slot_ff;
   logic wrapped_ff;
   logic [RW-1:0] rd_data;
   logic [RW-1:0] old_rate;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;

   hrpg_ram #(
      .WIDTH(RW),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (cmd.update),
      .wr_addr(slot_ff),
      .wr_data(rate_ff),
      .rd_en  (cmd.check),
      .rd_addr(slot_ff),
      .rd_data(rd_data)
   );

   assign old_rate = wrapped_ff ? rd_data : '0;
   assign sum_in = sum_ff - SUM_W'(old_rate) + SUM_W'(rate_ff);
   assign count_in = count_ff - CNT_W'(old_rate != '0) + CNT_W'(rate_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         wrapped_ff <= 1'b0;
         sum_ff <= '0;
         count_ff <= '0;
      end else if (cmd.update) begin
         sum_ff <= sum_in;
         count_ff <= count_in;
         if (slot_ff == SLOT_W'(RING_DEPTH - 1)) begin
            slot_ff <= '0;
            wrapped_ff <= 1'b1;
         end else begin
            slot_ff <= slot_ff + 1'b1;
         end
      end
   end

   // Restoring divider, one quotient bit per cycle. The dividend register
   // shifts out its top bit and takes the quotient bit in at the bottom.
   logic [SUM_W-1:0] dvd_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W:0] rem_shift;
   logic rem_ge;

   assign rem_shift = {rem_ff, dvd_ff[SUM_W-1]};
   assign rem_ge = rem_shift >= {1'b0, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         dvd_ff <= sum_in;
         rem_ff <= '0;
         step_ff <= STEP_W'(SUM_W - 1);
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[SUM_W-2:0], rem_ge};
         rem_ff <= rem_ge ? CNT_W'(rem_shift - {1'b0, count_ff}) : rem_shift[CNT_W-1:0];
         step_ff <= step_ff - 1'b1;
      end
   end

   assign status.store = store;
   assign status.div_done = (step_ff == '0);

   assign phase_ok = ok_ff;
   assign rate_valid = store_ff && (count_ff != '0);
   assign rate_mean = rate_valid ? dvd_ff[RW-1:0] : '0;

   // The nonzero count never exceeds the depth, nor the writes before wrap.
   a_count_le_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RING_DEPTH))
      else $error("nonzero count exceeds ring depth");

   a_count_le_slot: assert property (@(posedge clock) disable iff (reset)
      !wrapped_ff |-> (CNT_W'(slot_ff) >= count_ff))
      else $error("nonzero count exceeds written entries before wrap");

   a_store_needs_ok: assert property (@(posedge clock) disable iff (reset)
      store_ff |-> ok_ff)
      else $error("rate stored without phase acceptance");

   a_update_advances: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (slot_ff != $past(slot_ff)) || (RING_DEPTH == 1))
      else $error("write slot did not advance after update");

endmodule

// ===== design/heart_rate_phase_gate_average_unit.sv =====
// Heart-rate phase-gate average unit: top level joining controller,
// datapath and ring memory. Depends on hrpg_pkg, hrpg_req_if, hrpg_rsp_if,
// hrpg_ctrl and hrpg_dpath.
//
// Usage: a request transaction carries a heart phase sample and an optional
// raw rate; each request yields exactly one response transaction with the
// phase verdict and, when a rate was stored, the mean of the nonzero ring
// entries. Settings are written through the csr port while the unit is idle.
// The unit holds one transaction at a time. A request whose rate is not
// stored goes from the check state straight to the response state. A
// stored rate updates the ring, running sum and count, then runs a
// restoring divider that yields one quotient bit per cycle over
// 12 + clog2(RING_DEPTH + 1) bits before the response is offered. The
// next request is accepted in the cycle after the response is taken.
// While the receiver stalls, the response is held steady and no request is
// accepted. Reset restores the default settings, clears the prior phase,
// the write slot and the running sum; ring entries not yet written read as
// zero, so no clearing pass follows reset.
module heart_rate_phase_gate_average_unit #(
   parameter int RING_DEPTH = hrpg_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [hrpg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hrpg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   hrpg_req_if.sink                         req_ch,
   hrpg_rsp_if.source                       rsp_ch
);

   hrpg_pkg::hrpg_cmd_type cmd;
   hrpg_pkg::hrpg_status_type status;

   hrpg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .status   (status),
      .cmd      (cmd)
   );

   hrpg_dpath #(
      .RING_DEPTH(RING_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .phase_sample(req_ch.phase_sample),
      .rate_present(req_ch.rate_present),
      .raw_rate    (req_ch.raw_rate),
      .cmd         (cmd),
      .status      (status),
      .phase_ok    (rsp_ch.phase_ok),
      .rate_valid  (rsp_ch.rate_valid),
      .rate_mean   (rsp_ch.rate_mean)
   );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for heart_rate_phase_gate_average_unit: drives phase and rate samples,
// predicts each verdict and mean in step with the block, and checks every response.
// Depends on hrpg_pkg, hrpg_req_if, hrpg_rsp_if and the unit itself.
module tb;

   localparam int RING_DEPTH = hrpg_pkg::RING_DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 1000;
   localparam int RANDOM_PHASES = 7;
   localparam int SAMPLES_PER_PHASE = 150;
   localparam logic [hrpg_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

   typedef struct packed {
      logic signed [hrpg_pkg::PHASE_W-1:0] phase_sample;
      logic rate_present;
      logic [hrpg_pkg::RATE_W-1:0] raw_rate;
   } sample_type;

   typedef struct packed {
      logic phase_ok;
      logic rate_valid;
      logic [hrpg_pkg::RATE_W-1:0] rate_mean;
   } verdict_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [hrpg_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [hrpg_pkg::CSR_DATA_W-1:0] csr_wdata;

   hrpg_req_if req_ch ();
   hrpg_rsp_if rsp_ch ();

   heart_rate_phase_gate_average_unit #(
      .RING_DEPTH(RING_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mirror of the block's settings and state.
   logic [hrpg_pkg::LIMIT_W-1:0] jump_limit;
   logic [hrpg_pkg::RATE_W-1:0] rate_floor;
   logic [hrpg_pkg::RATE_W-1:0] rate_ceiling;
   logic [hrpg_pkg::RATE_W-1:0] ring_entries [RING_DEPTH];
   int next_slot;
   logic signed [hrpg_pkg::PHASE_W-1:0] last_phase;

   sample_type pending_samples[$];
   verdict_type expected_verdicts[$];
   sample_type outgoing;
   verdict_type want;
   verdict_type got;
   int samples_queued = 0;
   int verdicts_checked = 0;
   int mismatch_count = 0;
   int stall_cycles = 0;
   int gen_last_phase = 0;
   logic req_taken = 1'b0;
   logic calm = 1'b0;

   function automatic verdict_type gate_and_average(input sample_type s);
      verdict_type v;
      int jump;
      int total;
      int nonzero;
      v = '0;
      if (last_phase == 0) begin
         v.phase_ok = 1'b1;
      end else begin
         jump = $signed(s.phase_sample) - $signed(last_phase);
         if (jump < 0) begin
            jump = -jump;
         end
         v.phase_ok = (jump < int'(jump_limit));
      end
      last_phase = s.phase_sample;
      if (v.phase_ok && s.rate_present && s.raw_rate >= rate_floor
          && s.raw_rate <= rate_ceiling) begin
         ring_entries[next_slot] = s.raw_rate;
         next_slot = (next_slot == RING_DEPTH - 1) ? 0 : next_slot + 1;
         total = 0;
         nonzero = 0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            if (ring_entries[i] != 0) begin
               total += ring_entries[i];
               nonzero++;
            end
         end
         // Zero entries never count, so a ring of zeros gives no mean at all.
         if (nonzero != 0) begin
            v.rate_valid = 1'b1;
            v.rate_mean = hrpg_pkg::RATE_W'(total / nonzero);
         end
      end
      return v;
   endfunction

   // Request driver: a new transaction is offered only after the last one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
            outgoing = pending_samples.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.phase_sample <= outgoing.phase_sample;
            req_ch.rate_present <= outgoing.rate_present;
            req_ch.raw_rate <= outgoing.raw_rate;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= 23);
      end
   end

   // Monitor: checks responses and predicts the verdict of each accepted request.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.phase_ok, rsp_ch.rate_valid, rsp_ch.rate_mean};
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %b %b %0d",
                        $time, got.phase_ok, got.rate_valid, got.rate_mean);
               mismatch_count++;
            end else begin
               want = expected_verdicts.pop_front();
               verdicts_checked++;
               if (got.phase_ok !== want.phase_ok) begin
                  $display("%0t: phase_ok mismatch, expected %b, actual %b",
                           $time, want.phase_ok, got.phase_ok);
                  mismatch_count++;
               end
               if (got.rate_valid !== want.rate_valid) begin
                  $display("%0t: rate_valid mismatch, expected %b, actual %b",
                           $time, want.rate_valid, got.rate_valid);
                  mismatch_count++;
               end
               if (got.rate_mean !== want.rate_mean) begin
                  $display("%0t: rate_mean mismatch, expected %0d, actual %0d",
                           $time, want.rate_mean, got.rate_mean);
                  mismatch_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_verdicts.push_back(gate_and_average(
               '{req_ch.phase_sample, req_ch.rate_present, req_ch.raw_rate}));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("heart_rate_phase_gate_average_unit test failed");
         $finish;
      end
   end

   task automatic push_sample(input int phase, input logic present, input int rate);
      sample_type s;
      s.phase_sample = phase[hrpg_pkg::PHASE_W-1:0];
      s.rate_present = present;
      s.raw_rate = rate[hrpg_pkg::RATE_W-1:0];
      pending_samples.push_back(s);
      samples_queued++;
      gen_last_phase = phase;
   endtask

   task automatic drain_results();
      while (verdicts_checked < samples_queued) begin
         @(negedge clock);
      end
   endtask

   task automatic write_csr(input logic [hrpg_pkg::CSR_INDEX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[hrpg_pkg::CSR_DATA_W-1:0];
      case (idx)
         hrpg_pkg::REG_PHASE_LIMIT: jump_limit = value[hrpg_pkg::LIMIT_W-1:0];
         hrpg_pkg::REG_RATE_LOW: rate_floor = value[hrpg_pkg::RATE_W-1:0];
         hrpg_pkg::REG_RATE_HIGH: rate_ceiling = value[hrpg_pkg::RATE_W-1:0];
         default: ;
      endcase
   endtask

   // Every register is rewritten, and a write to the unmapped index must change nothing.
   task automatic configure(input int limit, input int low, input int high);
      write_csr(hrpg_pkg::REG_PHASE_LIMIT, limit);
      write_csr(hrpg_pkg::REG_RATE_LOW, low);
      write_csr(hrpg_pkg::REG_RATE_HIGH, high);
      write_csr(REG_UNMAPPED, $urandom_range(32767));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly small phase steps with in-range rates so the ring fills and wraps; the
   // rest sits on the jump and rate limits, zero phases, or is plain noise.
   task automatic queue_random_samples(input int count);
      int roll;
      int step;
      int phase;
      int rate;
      int lim;
      logic present;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         lim = jump_limit;
         present = 1'b1;
         if (roll < 60) begin
            step = 0;
            if (lim > 1) begin
               step = $urandom_range(2 * lim - 2);
               step = step - (lim - 1);
            end
            phase = gen_last_phase + step;
            if (rate_floor <= rate_ceiling) begin
               rate = $urandom_range(rate_ceiling, rate_floor);
            end else begin
               rate = $urandom_range(4095);
            end
         end else if (roll < 66) begin
            phase = 0;
            rate = $urandom_range(4095);
         end else if (roll < 76) begin
            step = $urandom_range(1) ? lim : lim - 1;
            if ($urandom_range(1)) begin
               step = -step;
            end
            phase = gen_last_phase + step;
            case ($urandom_range(3))
               0: rate = rate_floor;
               1: rate = rate_ceiling;
               2: rate = (rate_floor - 1) & 12'hFFF;
               default: rate = (rate_ceiling + 1) & 12'hFFF;
            endcase
         end else begin
            phase = $urandom_range(65535);
            phase = phase - 32768;
            present = 1'($urandom_range(1));
            rate = $urandom_range(4095);
         end
         if (phase > 32767) begin
            phase = 32767;
         end
         if (phase < -32768) begin
            phase = -32768;
         end
         push_sample(phase, present, rate);
      end
   endtask

   initial begin
      int low;
      int high;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.phase_sample = '0;
      req_ch.rate_present = 1'b0;
      req_ch.raw_rate = '0;
      rsp_ch.ready = 1'b0;
      jump_limit = hrpg_pkg::PHASE_LIMIT_RESET;
      rate_floor = hrpg_pkg::RATE_LOW_RESET;
      rate_ceiling = hrpg_pkg::RATE_HIGH_RESET;
      for (int i = 0; i < RING_DEPTH; i++) begin
         ring_entries[i] = '0;
      end
      next_slot = 0;
      last_phase = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: first sample, jumps on both sides of the limit, rate limits.
      push_sample(4096, 1'b1, 800);
      push_sample(4096 + 3276, 1'b1, 1920);
      push_sample(4096 + 3276 + 3277, 1'b1, 1000);
      push_sample(0, 1'b1, 640);
      push_sample(32767, 1'b1, 639);
      push_sample(32767 - 3276, 1'b1, 1921);
      push_sample(-32768, 1'b1, 1000);
      push_sample(-32668, 1'b0, 4095);
      push_sample(-32668, 1'b1, 1200);
      drain_results();

      // Zero limit and zero rates: zeros overwrite the whole ring, leaving no mean.
      configure(0, 0, 0);
      for (int i = 0; i < RING_DEPTH + 1; i++) begin
         push_sample(0, 1'b1, 0);
      end
      push_sample(5, 1'b1, 0);
      push_sample(5, 1'b1, 0);
      drain_results();

      configure(32767, 4095, 4095);
      push_sample(-32768, 1'b1, 4095);
      push_sample(-32768 + 767, 1'b1, 4095);
      drain_results();

      // With the floor above the ceiling nothing can be stored.
      configure(32767, 2000, 1000);
      push_sample(0, 1'b1, 1500);
      drain_results();

      for (int k = 0; k < RANDOM_PHASES; k++) begin
         low = $urandom_range(4095);
         high = $urandom_range(4095, low);
         case (k)
            0: configure(hrpg_pkg::PHASE_LIMIT_RESET, hrpg_pkg::RATE_LOW_RESET,
                         hrpg_pkg::RATE_HIGH_RESET);
            1: configure(32767, 0, 4095);
            2: configure($urandom_range(32767), low, high);
            3: configure(0, low, high);
            4: configure($urandom_range(32767), high, low);
            5: configure($urandom_range(64, 1), low, high);
            default: configure($urandom_range(8192), low, high);
         endcase
         calm = (k == 2);
         queue_random_samples(SAMPLES_PER_PHASE);
         // The sender holds off here until every verdict of this batch is back.
         drain_results();
      end
      calm = 1'b0;

      repeat (40) @(negedge clock);
      if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
         $display("heart_rate_phase_gate_average_unit test passed");
      end else begin
         $display("heart_rate_phase_gate_average_unit test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/hrpg_pkg.sv
design/hrpg_req_if.sv
design/hrpg_rsp_if.sv
design/hrpg_ram.sv
design/hrpg_ctrl.sv
design/hrpg_dpath.sv
design/heart_rate_phase_gate_average_unit.sv
verif/tb.sv
